// File: hw/rtl/lkv_pkg.sv
// lkv_pkg: shared sizes, types and codes for the lru key-value cache
// depends on nothing; used by lkv_slot and lru_key_value_cache
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;
  localparam int CMP_W   = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef logic [RANK_W-1:0]        rank_t;
  typedef logic [OCC_W-1:0]         occ_t;
  typedef logic [CAP_W-1:0]         cap_t;
  typedef logic [CMP_W-1:0]         cmp_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ENTRIES-1:0]       vec_t;

  // broadcast from the control logic to every slot
  typedef struct packed {
    logic  touch;        // request hit: refresh the matching slot
    logic  insert;       // put miss: insert a new key
    logic  put;          // request is a put
    logic  evict;        // insert must drop the least recent entry
    rank_t hit_rank;     // rank of the hit slot
    rank_t victim_rank;  // rank of the least recent entry
    data_t key;
    data_t value;
  } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key-value cache with lru replacement
// depends on lkv_pkg and lkv_slot
`timescale 1ns / 1ps
`default_nettype none

// usage
//   request channel: drive req_type, key, value and raise start; a word is
//     taken at every rising edge with start high and busy low. busy stays
//     low, so one word can be taken every cycle
//   result channel: done is high for exactly one cycle per request, with
//     found and read_value valid in that cycle. the receiver cannot stall
//     it, so it must sample the word while done is high
//   latency: a word taken at edge n shows its result in the cycle after
//     edge n+1 (two register stages: request register, result register)
//   throughput: one request per cycle. all slots compare keys and update
//     ranks in parallel in the cycle after the request register, so the
//     next request already sees the updated recency
//   configuration: cfg_we/cfg_wdata write capacity in one edge, only while
//     no request is in flight. capacity zero acts as one, above the entry
//     count it acts as the entry count. lowering it evicts nothing at once
//   reset: rst (synchronous) empties the cache, clears occupancy and any
//     request in flight and sets capacity to 16
//   get hit returns the value and refreshes recency; get miss and every put
//     return read_value zero; found tells whether the key was present
module lru_key_value_cache (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       req_type,
  input  wire logic signed [31:0]         key,
  input  wire logic signed [31:0]         value,
  output logic                            done,
  output logic                            found,
  output logic signed [31:0]              read_value,
  input  wire logic                       cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0]  cfg_wdata
);

  // configuration and occupancy
  lkv_pkg::cap_t  capacity;
  lkv_pkg::occ_t  occ;
  lkv_pkg::occ_t  occ_next;

  // request register
  logic           q_valid;
  logic           q_put;
  lkv_pkg::data_t q_key;
  lkv_pkg::data_t q_value;

  // slot side
  lkv_pkg::cmd_t  cmd;
  lkv_pkg::vec_t  slot_valid;
  lkv_pkg::vec_t  slot_match;
  lkv_pkg::vec_t  slot_victim;
  lkv_pkg::vec_t  free_vec;
  lkv_pkg::vec_t  pick;
  lkv_pkg::rank_t slot_rank [lkv_pkg::ENTRIES];
  lkv_pkg::data_t slot_value [lkv_pkg::ENTRIES];

  // lookup results
  logic           hit;
  lkv_pkg::rank_t hit_rank;
  lkv_pkg::data_t hit_value;
  lkv_pkg::cmp_t  cap_x;
  lkv_pkg::cmp_t  occ_x;
  lkv_pkg::cmp_t  eff_cap;
  logic           need_evict;

  // every request finishes in one pass, so there is never back-pressure
  assign busy = 1'b0;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q_put   <= (req_type == lkv_pkg::REQ_PUT);
      q_key   <= key;
      q_value <= value;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // keys are unique among valid slots, so an or-mux picks the hit slot
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      if (slot_match[i]) begin
        hit_rank  = hit_rank | slot_rank[i];
        hit_value = hit_value | slot_value[i];
      end
    end
  end

  assign hit = |slot_match;

  // clamp capacity to 1 .. entries
  always_comb begin
    cap_x = lkv_pkg::cmp_t'(capacity);
    occ_x = lkv_pkg::cmp_t'(occ);
    if (cap_x == '0) begin
      eff_cap = lkv_pkg::cmp_t'(1);
    end else if (cap_x > lkv_pkg::cmp_t'(lkv_pkg::ENTRIES)) begin
      eff_cap = lkv_pkg::cmp_t'(lkv_pkg::ENTRIES);
    end else begin
      eff_cap = cap_x;
    end
  end

  assign need_evict = ((occ_x + lkv_pkg::cmp_t'(1)) > eff_cap) ||
                      (occ_x >= lkv_pkg::cmp_t'(lkv_pkg::ENTRIES));

  // command broadcast to the slots
  always_comb begin
    cmd.touch       = q_valid && hit;
    cmd.insert      = q_valid && q_put && !hit;
    cmd.put         = q_put;
    cmd.evict       = need_evict;
    cmd.hit_rank    = hit_rank;
    // ranks of valid slots run 0 .. occ-1, so the oldest holds occ-1
    cmd.victim_rank = lkv_pkg::rank_t'(occ - lkv_pkg::occ_t'(1));
    cmd.key         = q_key;
    cmd.value       = q_value;
  end

  // new key goes to the lowest free slot, counting the one being evicted
  assign free_vec = ~(slot_valid & ~slot_victim);
  assign pick     = cmd.insert ? (free_vec & (~free_vec + lkv_pkg::vec_t'(1))) : '0;

  for (genvar i = 0; i < lkv_pkg::ENTRIES; i++) begin : g_slot
    lkv_slot u_slot (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .pick   (pick[i]),
      .valid  (slot_valid[i]),
      .rank   (slot_rank[i]),
      .value  (slot_value[i]),
      .match  (slot_match[i]),
      .victim (slot_victim[i])
    );
  end

  // occupancy: an insert adds one unless it also evicts
  always_comb begin
    occ_next = occ;
    if (cmd.insert && !need_evict) begin
      occ_next = occ + lkv_pkg::occ_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid) begin
      found      <= hit;
      read_value <= (!q_put && hit) ? hit_value : '0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lkv_slot.sv
// lkv_slot: one cache entry with its key compare and recency rank update
// depends on lkv_pkg
`timescale 1ns / 1ps
`default_nettype none

module lkv_slot (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lkv_pkg::cmd_t cmd,
  input  wire logic          pick,
  output logic               valid,
  output lkv_pkg::rank_t     rank,
  output lkv_pkg::data_t     value,
  output logic               match,
  output logic               victim
);

  lkv_pkg::data_t key;

  assign match  = valid && (key == cmd.key);
  assign victim = valid && cmd.evict && (rank == cmd.victim_rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.touch) begin
      if (match) begin
        rank <= '0;
      end else if (valid && (rank < cmd.hit_rank)) begin
        rank <= rank + lkv_pkg::rank_t'(1);
      end
    end else if (cmd.insert) begin
      if (pick) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (victim) begin
        valid <= 1'b0;
        rank  <= '0;
      end else if (valid) begin
        rank <= rank + lkv_pkg::rank_t'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.touch && match && cmd.put) begin
      value <= cmd.value;
    end else if (cmd.insert && pick) begin
      key   <= cmd.key;
      value <= cmd.value;
    end
  end

endmodule

`default_nettype wire
